>>> sv/bsc_pkg.sv
// Package for the bitmap block: action codes, widths, default size and
// the highest-set-bit encoder shared by the design.
// Depends on nothing.
`timescale 1ns / 1ps

package bsc_pkg;

   localparam int MAX_BITS_DEFAULT = 1024;
   localparam int WORD_BITS        = 32;
   localparam int POS_W            = 10;
   localparam int SIZE_W           = 11;
   localparam int WIDX_W           = 5;
   localparam int BIT_W            = 5;
   localparam int ACTION_W         = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 3;

   localparam logic [ACTION_W-1:0] ACT_SET         = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR       = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SET_RANGE   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR_RANGE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_TEST        = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_FIND        = 3'd5;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
   localparam logic [SIZE_W-1:0] IDX_NONE   = 11'h7FF;

   localparam logic [WORD_BITS-1:0] ONES = '1;

   // Index of the highest set bit of a non-zero word, found by halving.
   function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_BITS-1:0] w);
      logic [WORD_BITS-1:0] v;
      logic [BIT_W-1:0]     b;
      v = w;
      b = '0;
      if (v[31:16] != '0) begin
         b[4] = 1'b1;
         v    = v >> 16;
      end
      if (v[15:8] != '0) begin
         b[3] = 1'b1;
         v    = v >> 8;
      end
      if (v[7:4] != '0) begin
         b[2] = 1'b1;
         v    = v >> 4;
      end
      if (v[3:2] != '0) begin
         b[1] = 1'b1;
         v    = v >> 2;
      end
      if (v[1]) begin
         b[0] = 1'b1;
      end
      return b;
   endfunction

endpackage

>>> sv/bitmap_set_clear_find_highest.sv
// Bitmap held in a word memory, with set, clear, range update, test and
// find-highest-set requests, and an APB-style size register.
// Depends on bsc_pkg.
// Single-bit requests pass through ST_BIT before the registered strobe; rejected ones strobe
// straight from idle. Range updates and find visit one memory word a cycle.
// busy falls as the strobe rises, so the next item may be accepted in the strobe cycle.
// After reset a clearing pass writes zero to every memory word and holds busy high.
// Results cannot be stalled; each one is shown for exactly one cycle.
`timescale 1ns / 1ps

module bitmap_set_clear_find_highest #(
   parameter int MAX_BITS = bsc_pkg::MAX_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [bsc_pkg::ACTION_W-1:0]           req_action,
   input  logic [bsc_pkg::POS_W-1:0]              req_position,
   input  logic [bsc_pkg::POS_W-1:0]              req_range_end,
   output logic                                   rsp_valid,
   output logic                                   rsp_old_bit,
   output logic signed [bsc_pkg::SIZE_W-1:0]      rsp_highest_index,
   output logic                                   rsp_out_of_range,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [bsc_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [bsc_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [bsc_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);

   localparam int WORD_COUNT = (MAX_BITS + bsc_pkg::WORD_BITS - 1) / bsc_pkg::WORD_BITS;
   localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int XW         = (AW > bsc_pkg::WIDX_W) ? AW : bsc_pkg::WIDX_W;
   localparam int CMP_W      = 17;
   localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);
   localparam logic [bsc_pkg::SIZE_W-1:0] POS_LAST =
      bsc_pkg::SIZE_W'((1 << bsc_pkg::POS_W) - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BIT,
      ST_RANGE,
      ST_FIND
   } state_type;

   state_type state_ff, state_in;

   logic [bsc_pkg::WORD_BITS-1:0] mem [WORD_COUNT];
   logic [bsc_pkg::WORD_BITS-1:0] rdata_ff;

   logic [AW-1:0]                 clr_ff, clr_in;
   logic [bsc_pkg::SIZE_W-1:0]    size_ff;
   logic [bsc_pkg::ACTION_W-1:0]  act_ff, act_in;
   logic [bsc_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [bsc_pkg::POS_W-1:0]     lo_ff, lo_in;
   logic [bsc_pkg::POS_W-1:0]     hi_ff, hi_in;
   logic [bsc_pkg::POS_W-1:0]     lim_ff, lim_in;
   logic [bsc_pkg::WIDX_W-1:0]    widx_ff, widx_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          old_bit_ff, old_bit_in;
   logic [bsc_pkg::SIZE_W-1:0]    hidx_ff, hidx_in;
   logic                          oor_ff, oor_in;

   logic [bsc_pkg::SIZE_W-1:0]    eff_size;
   logic [bsc_pkg::SIZE_W-1:0]    eff_last;
   logic [bsc_pkg::SIZE_W-1:0]    find_last;
   logic [bsc_pkg::POS_W-1:0]     req_lo;
   logic [bsc_pkg::POS_W-1:0]     req_hi;

   logic [bsc_pkg::WIDX_W-1:0]    rd_idx;
   logic [XW-1:0]                 rd_ext;
   logic [AW-1:0]                 rd_addr;
   logic [XW-1:0]                 wr_ext;
   logic [AW-1:0]                 wr_addr;
   logic                          we;
   logic                          wr_clear;
   logic [bsc_pkg::WORD_BITS-1:0] wdata;

   logic [bsc_pkg::BIT_W-1:0]     low_b;
   logic [bsc_pkg::BIT_W-1:0]     high_b;
   logic [bsc_pkg::WORD_BITS-1:0] range_mask;
   logic [bsc_pkg::WORD_BITS-1:0] bit_mask;
   logic [bsc_pkg::WORD_BITS-1:0] find_mask;
   logic [bsc_pkg::WORD_BITS-1:0] find_word;

   // Size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= bsc_pkg::SIZE_RESET;
      end else if (psel && penable && pwrite && pready && !paddr[2]) begin
         size_ff <= pwdata[bsc_pkg::SIZE_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? '0 : bsc_pkg::CSR_DATA_W'(size_ff);

   always_comb begin
      if (CMP_W'(size_ff) < CMP_W'(MAX_BITS)) begin
         eff_size = size_ff;
      end else begin
         eff_size = bsc_pkg::SIZE_W'(MAX_BITS);
      end
   end

   // The search starts at the last position inside the effective size; bits above it are masked off.
   assign eff_last  = eff_size - 11'd1;
   assign find_last = (eff_last > POS_LAST) ? POS_LAST : eff_last;
   assign req_lo    = (req_position < req_range_end) ? req_position : req_range_end;
   assign req_hi    = (req_position < req_range_end) ? req_range_end : req_position;

   // Word masks for the word being visited.
   assign low_b      = (widx_ff == lo_ff[9:5]) ? lo_ff[4:0] : 5'd0;
   assign high_b     = (widx_ff == hi_ff[9:5]) ? hi_ff[4:0] : 5'd31;
   assign range_mask = (bsc_pkg::ONES << low_b) & (bsc_pkg::ONES >> (5'd31 - high_b));
   assign bit_mask   = bsc_pkg::WORD_BITS'(1) << pos_ff[4:0];
   assign find_mask  = (widx_ff == lim_ff[9:5]) ? (bsc_pkg::ONES >> (5'd31 - lim_ff[4:0]))
                                                : bsc_pkg::ONES;
   assign find_word  = rdata_ff & find_mask;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      act_in       = act_ff;
      pos_in       = pos_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lim_in       = lim_ff;
      widx_in      = widx_ff;
      rsp_valid_in = 1'b0;
      old_bit_in   = old_bit_ff;
      hidx_in      = hidx_ff;
      oor_in       = oor_ff;
      rd_idx       = widx_ff;
      we           = 1'b0;
      wr_clear     = 1'b0;
      wdata        = '0;

      case (state_ff)
         ST_CLEAR: begin
            we       = 1'b1;
            wr_clear = 1'b1;
            if (clr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            rd_idx = req_position[9:5];
            if (start) begin
               act_in     = req_action;
               pos_in     = req_position;
               lo_in      = req_lo;
               hi_in      = req_hi;
               lim_in     = find_last[bsc_pkg::POS_W-1:0];
               old_bit_in = 1'b0;
               hidx_in    = bsc_pkg::IDX_NONE;
               oor_in     = 1'b0;
               case (req_action) inside
                  bsc_pkg::ACT_SET, bsc_pkg::ACT_CLEAR, bsc_pkg::ACT_TEST: begin
                     if (bsc_pkg::SIZE_W'(req_position) >= eff_size) begin
                        oor_in       = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_BIT;
                     end
                  end
                  bsc_pkg::ACT_SET_RANGE, bsc_pkg::ACT_CLEAR_RANGE: begin
                     rd_idx = req_lo[9:5];
                     if (bsc_pkg::SIZE_W'(req_hi) >= eff_size) begin
                        oor_in       = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        widx_in  = req_lo[9:5];
                        state_in = ST_RANGE;
                     end
                  end
                  bsc_pkg::ACT_FIND: begin
                     rd_idx = find_last[9:5];
                     if (eff_size == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        widx_in  = find_last[9:5];
                        state_in = ST_FIND;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_BIT: begin
            old_bit_in   = rdata_ff[pos_ff[4:0]];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (act_ff == bsc_pkg::ACT_SET) begin
               we    = 1'b1;
               wdata = rdata_ff | bit_mask;
            end else if (act_ff == bsc_pkg::ACT_CLEAR) begin
               we    = 1'b1;
               wdata = rdata_ff & ~bit_mask;
            end
         end
         ST_RANGE: begin
            we     = 1'b1;
            wdata  = (act_ff == bsc_pkg::ACT_SET_RANGE) ? (rdata_ff | range_mask)
                                                         : (rdata_ff & ~range_mask);
            rd_idx = widx_ff + 5'd1;
            if (widx_ff == hi_ff[9:5]) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               widx_in = widx_ff + 5'd1;
            end
         end
         ST_FIND: begin
            rd_idx = widx_ff - 5'd1;
            if (find_word != '0) begin
               hidx_in      = {1'b0, widx_ff, bsc_pkg::top_bit(find_word)};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (widx_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               widx_in = widx_ff - 5'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_ext  = XW'(rd_idx);
   assign rd_addr = rd_ext[AW-1:0];
   assign wr_ext  = XW'(state_ff == ST_BIT ? pos_ff[9:5] : widx_ff);
   assign wr_addr = wr_clear ? clr_ff : wr_ext[AW-1:0];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff     <= act_in;
      pos_ff     <= pos_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      lim_ff     <= lim_in;
      widx_ff    <= widx_in;
      old_bit_ff <= old_bit_in;
      hidx_ff    <= hidx_in;
      oor_ff     <= oor_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_old_bit       = old_bit_ff;
   assign rsp_highest_index = hidx_ff;
   assign rsp_out_of_range  = oor_ff;

endmodule
